### hw/rtl/rcc_pkg.sv
// Package for the RC channel classifier.
// Holds the transfer payload types, configuration struct, mode codes and decode constants.
// No dependencies.
`default_nettype none

package rcc_pkg;

  localparam int CH_W    = 4;
  localparam int PW_W    = 12;
  localparam int MODES_W = 48;
  localparam int COUNT_W = 5;
  localparam int DB_W    = 10;
  localparam int IDX_W   = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_CHANNEL_MODES = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEAD_BAND     = 2'd2;

  localparam logic [MODES_W-1:0] MODES_RESET = 48'd484139657;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;
  localparam logic [DB_W-1:0]    DB_RESET    = 10'd30;

  // Pulse width thresholds in microseconds
  localparam logic [PW_W-1:0] PW_CENTER   = 12'd1500;
  localparam logic [PW_W-1:0] PW_THR_MIN  = 12'd1000;
  localparam logic [PW_W-1:0] PW_THR_LOW  = 12'd1070;
  localparam logic [PW_W-1:0] PW_THR_HIGH = 12'd1120;
  localparam logic [PW_W-1:0] PW_THR_MAX  = 12'd2000;
  localparam logic [PW_W-1:0] PW_SW_LOW   = 12'd1300;
  localparam logic [PW_W-1:0] PW_SW_HIGH  = 12'd1600;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_DEADBAND = 3'd1,
    MODE_THROTTLE = 3'd2,
    MODE_TOGGLE   = 3'd3,
    MODE_PUSH     = 3'd4,
    MODE_SEQUENCE = 3'd5,
    MODE_SWITCH   = 3'd6
  } mode_e;

  localparam logic [1:0] THR_NULL = 2'd0;
  localparam logic [1:0] THR_LOW  = 2'd1;
  localparam logic [1:0] THR_HIGH = 2'd2;

  localparam logic [1:0] SW_POS1  = 2'd0;
  localparam logic [1:0] SW_POS2  = 2'd1;
  localparam logic [1:0] SW_POS3  = 2'd2;
  localparam logic [1:0] SW_ERROR = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [PW_W-1:0] pulse_width;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] channel_out;
    logic [PW_W-1:0] value_out;
    logic [1:0]      throttle_level;
    logic [1:0]      switch_position;
    logic            toggle_state;
    logic            button_level;
  } out_item_t;

  typedef struct packed {
    logic [MODES_W-1:0] channel_modes;
    logic [COUNT_W-1:0] channel_count;
    logic [DB_W-1:0]    dead_band;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/rcc_cfg_regs.sv
// Configuration register file of the RC channel classifier.
// Depends on rcc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module rcc_cfg_regs
  import rcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_index,
  input  wire logic [MODES_W-1:0]   wr_data,
  output cfg_t                      cfg
);

  // Write one register per transfer; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_modes <= MODES_RESET;
      cfg.channel_count <= COUNT_RESET;
      cfg.dead_band     <= DB_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANNEL_MODES: cfg.channel_modes <= wr_data;
        REG_CHANNEL_COUNT: cfg.channel_count <= wr_data[COUNT_W-1:0];
        REG_DEAD_BAND:     cfg.dead_band     <= wr_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rcc_core.sv
// Per-channel state and classification logic of the RC channel classifier.
// Depends on rcc_pkg; the result is combinational from the held item and state.
`default_nettype none

module rcc_core
  import rcc_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   update,
  input  in_item_t    item,
  input  cfg_t        cfg,
  output out_item_t   res
);

  localparam int SIDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W:0] NUM_CH = (CH_W+1)'(NUM_CHANNELS);

  logic [NUM_CHANNELS-1:0] last_level;
  logic [NUM_CHANNELS-1:0] toggle_bits;
  logic [1:0]              throttle_levels [NUM_CHANNELS];
  logic [1:0]              switch_positions [NUM_CHANNELS];

  logic [SIDX_W-1:0] idx;
  logic              in_range;
  logic              analysed;
  logic [5:0]        mode_base;
  mode_e             mode;
  logic              lvl;
  logic [PW_W-1:0]   pw;
  logic [PW_W-1:0]   center_dist;
  logic [PW_W-1:0]   value;
  logic              lst_cur, tgl_cur;
  logic [1:0]        thr_cur, sw_cur;
  logic              lst_new, tgl_new;
  logic [1:0]        thr_new, sw_new;

  assign pw          = item.pulse_width;
  assign idx         = item.channel[SIDX_W-1:0];
  assign in_range    = {1'b0, item.channel} < NUM_CH;
  assign analysed    = in_range && ({1'b0, item.channel} < cfg.channel_count);
  assign mode_base   = {2'b00, item.channel} * 6'd3;
  assign mode        = mode_e'(cfg.channel_modes[mode_base +: 3]);
  assign lvl         = pw > PW_CENTER;
  assign center_dist = (pw >= PW_CENTER) ? (pw - PW_CENTER) : (PW_CENTER - pw);

  // Read the stored state of the channel
  always_comb begin
    lst_cur = 1'b0;
    tgl_cur = 1'b0;
    thr_cur = THR_NULL;
    sw_cur  = SW_POS1;
    if (in_range) begin
      lst_cur = last_level[idx];
      tgl_cur = toggle_bits[idx];
      thr_cur = throttle_levels[idx];
      sw_cur  = switch_positions[idx];
    end
  end

  // Apply the channel mode
  always_comb begin
    value   = pw;
    lst_new = lst_cur;
    tgl_new = tgl_cur;
    thr_new = thr_cur;
    sw_new  = sw_cur;
    if (analysed) begin
      case (mode)
        MODE_DEADBAND: begin
          if (center_dist < {2'b00, cfg.dead_band}) value = PW_CENTER;
        end
        MODE_THROTTLE: begin
          if (pw > PW_THR_MIN && pw <= PW_THR_LOW) thr_new = THR_NULL;
          else if (pw > PW_THR_LOW && pw <= PW_THR_HIGH) thr_new = THR_LOW;
          else if (pw > PW_THR_HIGH && pw < PW_THR_MAX) thr_new = THR_HIGH;
        end
        MODE_TOGGLE: begin
          if (lvl != lst_cur) tgl_new = ~tgl_cur;
          lst_new = lvl;
        end
        MODE_PUSH: begin
          if (lvl && !lst_cur) tgl_new = 1'b1;
          lst_new = lvl;
        end
        MODE_SWITCH: begin
          if (pw < PW_SW_LOW) sw_new = SW_POS1;
          else if (pw > PW_SW_LOW && pw < PW_SW_HIGH) sw_new = SW_POS2;
          else if (pw > PW_SW_HIGH) sw_new = SW_POS3;
          else sw_new = SW_ERROR;
        end
        default: ;
      endcase
    end
  end

  // Report the updated state of the channel
  always_comb begin
    res.channel_out     = item.channel;
    res.value_out       = value;
    res.throttle_level  = thr_new;
    res.switch_position = sw_new;
    res.toggle_state    = tgl_new;
    res.button_level    = lst_new;
  end

  // Write back state when the item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= '0;
      toggle_bits <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        throttle_levels[i]  <= THR_NULL;
        switch_positions[i] <= SW_POS1;
      end
    end else if (update && analysed) begin
      last_level[idx]       <= lst_new;
      toggle_bits[idx]      <= tgl_new;
      throttle_levels[idx]  <= thr_new;
      switch_positions[idx] <= sw_new;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rc_channel_classifier_unit.sv
// RC channel classifier: input register, classification logic, result register.
// Flow: the input register holds an item, the core classifies it and its result is captured
// in the result register; throughput one item per cycle while out_ready does not stall it,
// set by the single state read-modify-write between the input and result registers.
// Synchronous active-high reset clears per-channel state, pipeline valids and restores
// the configuration register reset values. Configuration writes are always accepted.
// Depends on rcc_pkg, rcc_cfg_regs and rcc_core.
`default_nettype none

module rc_channel_classifier_unit
  import rcc_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [MODES_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid;
  out_item_t res;
  logic      advance;

  assign cfg_ready = 1'b1;

  rcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held item to the result register when that register is free
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  rcc_core #(.NUM_CHANNELS(NUM_CHANNELS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .update (s1_valid && advance),
    .item   (s1_item),
    .cfg    (cfg),
    .res    (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_item <= in_data;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) out_data <= res;
  end

endmodule

`default_nettype wire
